>>> src/assert_macros.svh
// Assertion macros shared by the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: %m");

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition: %m");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

>>> src/fmps_pkg.sv
`timescale 1ns / 1ps

package fmps_pkg;

    // Access kinds carried on the input channel.
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Bus ports of the emulated card.
    localparam logic [1:0] PORT_PRI_INDEX = 2'd0;
    localparam logic [1:0] PORT_PRI_DATA  = 2'd1;
    localparam logic [1:0] PORT_SEC_INDEX = 2'd2;
    localparam logic [1:0] PORT_SEC_DATA  = 2'd3;

    // Register indexes with special handling.
    localparam logic [7:0] IDX_TIMER_CTRL = 8'd4;
    localparam logic [7:0] IDX_VOL_LEFT   = 8'd9;
    localparam logic [7:0] IDX_VOL_RIGHT  = 8'd10;

    // Extended control codes on the secondary index port.
    localparam logic [7:0] EXT_ENABLE_CODE  = 8'hFF;
    localparam logic [7:0] EXT_DISABLE_CODE = 8'hFE;
    localparam logic [7:0] EXT_ID_BYTE      = 8'hBF;

    // Timer control and status bits.
    localparam logic [7:0] T1_START_BIT   = 8'h01;
    localparam logic [7:0] T2_START_BIT   = 8'h02;
    localparam logic [7:0] T1_STATUS_BITS = 8'hC0;
    localparam logic [7:0] T2_STATUS_BITS = 8'hA0;

    // Reset values.
    localparam logic [7:0] VOLUME_RESET = 8'h08;
    localparam logic [7:0] LIMIT_RESET  = 8'(71 / 4);
    localparam logic [7:0] COUNT_MAX    = 8'hFF;

    // One accepted input beat.
    typedef struct packed {
        logic [1:0] cmd;
        logic [1:0] port_select;
        logic [7:0] write_data;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic [7:0] read_data;
        logic       forward_valid;
        logic       forward_bank;
        logic [7:0] forward_index;
        logic [7:0] forward_data;
        logic       forward_queued;
        logic       flush_request;
    } result_t;

    // Width of the result channel's tdata, rounded up to whole bytes.
    localparam int RESULT_BITS = $bits(result_t);
    localparam int M_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;

endpackage

>>> src/fmps_in_stage.sv
`timescale 1ns / 1ps

module fmps_in_stage
    import fmps_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     take,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // The register is free when empty or when its beat moves on this cycle.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !take);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded on every accepted beat.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> src/fmps_core.sv
`timescale 1ns / 1ps

module fmps_core
    import fmps_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       take,
    input  in_item_t   item,
    output result_t    result
);

    logic [7:0] limit_reg;
    logic [7:0] pri_index_reg, sec_index_reg;
    logic [7:0] timer1_reg, timer2_reg;
    logic       ext_en_reg;
    logic [7:0] vol_left_reg, vol_right_reg;
    logic [7:0] count_reg;

    logic [7:0] pri_index_next, sec_index_next;
    logic [7:0] timer1_next, timer2_next;
    logic       ext_en_next;
    logic [7:0] vol_left_next, vol_right_next;
    logic [7:0] count_next;

    logic [7:0] status;
    logic       sec_is_vol;
    logic [7:0] vol_sel;
    logic [7:0] count_inc;

    // Emulated status byte: a timer reads expired when started and not masked.
    always_comb begin
        status = '0;
        if ((timer1_reg & (T1_STATUS_BITS | T1_START_BIT)) == T1_START_BIT) begin
            status = status | T1_STATUS_BITS;
        end
        if ((timer2_reg & (T2_STATUS_BITS | T2_START_BIT)) == T2_START_BIT) begin
            status = status | T2_STATUS_BITS;
        end
    end

    assign sec_is_vol = (sec_index_reg == IDX_VOL_LEFT) || (sec_index_reg == IDX_VOL_RIGHT);
    // Index 9 selects the left volume, index 10 the right one.
    assign vol_sel    = sec_index_reg[0] ? vol_left_reg : vol_right_reg;
    assign count_inc  = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;

    // Result and next state for the beat in the input register.
    always_comb begin
        result         = '0;
        pri_index_next = pri_index_reg;
        sec_index_next = sec_index_reg;
        timer1_next    = timer1_reg;
        timer2_next    = timer2_reg;
        ext_en_next    = ext_en_reg;
        vol_left_next  = vol_left_reg;
        vol_right_next = vol_right_reg;
        count_next     = count_reg;
        case (item.cmd)
            CMD_READ: begin
                if (item.port_select == PORT_SEC_INDEX && ext_en_reg) begin
                    result.read_data = EXT_ID_BYTE;
                end else if (item.port_select == PORT_SEC_DATA && sec_is_vol) begin
                    result.read_data = vol_sel;
                end else begin
                    result.read_data = status;
                end
            end
            CMD_WRITE: begin
                case (item.port_select)
                    PORT_PRI_INDEX: begin
                        pri_index_next = item.write_data;
                    end
                    PORT_SEC_INDEX: begin
                        if (item.write_data == EXT_ENABLE_CODE) begin
                            ext_en_next = 1'b1;
                        end else if (item.write_data == EXT_DISABLE_CODE) begin
                            ext_en_next = 1'b0;
                        end
                        sec_index_next = item.write_data;
                    end
                    default: begin
                        // Data ports forward the write with bank and latched index.
                        result.forward_valid  = 1'b1;
                        result.forward_data   = item.write_data;
                        result.forward_queued = (count_reg >= limit_reg);
                        count_next            = count_inc;
                        if (item.port_select == PORT_PRI_DATA) begin
                            result.forward_bank  = 1'b0;
                            result.forward_index = pri_index_reg;
                            if (pri_index_reg == IDX_TIMER_CTRL) begin
                                if ((item.write_data & (T1_START_BIT | T1_STATUS_BITS)) != '0) begin
                                    timer1_next = item.write_data;
                                end
                                if ((item.write_data & (T2_START_BIT | T2_STATUS_BITS)) != '0) begin
                                    timer2_next = item.write_data;
                                end
                            end
                        end else begin
                            result.forward_bank  = 1'b1;
                            result.forward_index = sec_index_reg;
                            if (sec_index_reg == IDX_VOL_LEFT) begin
                                vol_left_next = item.write_data;
                            end else if (sec_index_reg == IDX_VOL_RIGHT) begin
                                vol_right_next = item.write_data;
                            end
                        end
                    end
                endcase
            end
            CMD_TICK: begin
                count_next           = '0;
                result.flush_request = 1'b1;
            end
            default: begin
                // Unused code: no state change, all-zero result.
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Card state advances once per beat handed to the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pri_index_reg <= '0;
            sec_index_reg <= '0;
            timer1_reg    <= '0;
            timer2_reg    <= '0;
            ext_en_reg    <= 1'b0;
            vol_left_reg  <= VOLUME_RESET;
            vol_right_reg <= VOLUME_RESET;
            count_reg     <= '0;
        end else if (take) begin
            pri_index_reg <= pri_index_next;
            sec_index_reg <= sec_index_next;
            timer1_reg    <= timer1_next;
            timer2_reg    <= timer2_next;
            ext_en_reg    <= ext_en_next;
            vol_left_reg  <= vol_left_next;
            vol_right_reg <= vol_right_next;
            count_reg     <= count_next;
        end
    end

endmodule

>>> src/fmps_out_stage.sv
`timescale 1ns / 1ps

module fmps_out_stage
    import fmps_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t result,
    output logic    can_load,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // A new beat may enter when the register is empty or being drained.
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

>>> src/fm_synth_port_trap_shim_core.sv
// Port emulation for a two-bank FM synthesizer card. Each input beat is one bus
// access (read or write on one of the four ports) or a timer tick, and yields
// exactly one result beat: the read byte, the forwarded write with its bank,
// latched index and immediate/queued mark, a flush request, or an all-zero beat
// for an index write. A beat passes an input register, combinational decode and
// state update, and an output register, and waits in the input register while
// the output register is stalled. One beat is accepted every cycle
// while the result side keeps up. The limit register may be written at any time
// the block is idle; it takes effect on the next beat.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fm_synth_port_trap_shim_core
    import fmps_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Limit register write port.
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    // Input channel.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] write_data
    input  logic [3:0]           s_axis_tuser,  // [1:0] cmd, [3:2] port_select
    // Result channel.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] read_data, [8] forward_valid, [9] forward_bank, [17:10] forward_index,
    // [25:18] forward_data, [26] forward_queued, [27] flush_request, rest zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    in_item_t in_item;
    in_item_t item;
    logic     item_valid;
    logic     can_load;
    logic     take;
    result_t  result;
    result_t  out_result;

    assign in_item.cmd         = s_axis_tuser[1:0];
    assign in_item.port_select = s_axis_tuser[3:2];
    assign in_item.write_data  = s_axis_tdata;

    // A beat leaves the input register when the output register can hold it.
    assign take = item_valid && can_load;

    fmps_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    fmps_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .take        (take),
        .item        (item),
        .result      (result)
    );

    fmps_out_stage u_out_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (take),
        .result     (result),
        .can_load   (can_load),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    // Result fields packed from the lowest bit up.
    always_comb begin
        m_axis_tdata        = '0;
        m_axis_tdata[7:0]   = out_result.read_data;
        m_axis_tdata[8]     = out_result.forward_valid;
        m_axis_tdata[9]     = out_result.forward_bank;
        m_axis_tdata[17:10] = out_result.forward_index;
        m_axis_tdata[25:18] = out_result.forward_data;
        m_axis_tdata[26]    = out_result.forward_queued;
        m_axis_tdata[27]    = out_result.flush_request;
    end

    // A stalled result beat is never overwritten by a new one.
    `ASSERT_NEVER(a_no_overwrite, aclk, aresetn, take && m_axis_tvalid && !m_axis_tready)

    // A beat is either a read, a forwarded write or a tick, never two of them.
    `ASSERT_NEVER(a_fwd_flush_excl, aclk, aresetn,
                  m_axis_tvalid && out_result.forward_valid && out_result.flush_request)

    // Writes and ticks return a zero read byte.
    `ASSERT_CLK(a_read_zero, aclk, aresetn,
                (m_axis_tvalid && (out_result.forward_valid || out_result.flush_request))
                |-> (out_result.read_data == '0))

    // A beat handed on is visible on the result side in the next cycle.
    `ASSERT_CLK(a_take_shows, aclk, aresetn, take |=> m_axis_tvalid)

endmodule
